// ===== rtl/core/set_assoc_write_through_cache_unit_macros.svh =====
// Assertion macros for the set-associative write-through cache unit.
// Included by the top level; no other dependencies.
`ifndef SET_ASSOC_WRITE_THROUGH_CACHE_UNIT_MACROS_SVH
`define SET_ASSOC_WRITE_THROUGH_CACHE_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SAWTC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle check");

// Next-cycle implication, disabled while reset is asserted.
`define SAWTC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle check");

`endif

// ===== rtl/core/sawtc_pkg.sv =====
// Shared types, codes and default sizes for the write-through cache unit.
// No dependencies.
`default_nettype none

package sawtc_pkg;

  // Default geometry.
  localparam int OffsetBitsDef = 6;
  localparam int WayBitsDef    = 3;
  localparam int SetBitsDef    = 7;

  // Request type codes.
  localparam logic [1:0] ReqRead  = 2'd0;
  localparam logic [1:0] ReqWrite = 2'd1;
  localparam logic [1:0] ReqFlush = 2'd2;
  localparam logic [1:0] ReqFill  = 2'd3;

  // Response kind codes.
  localparam logic [2:0] KindRead   = 3'd0;
  localparam logic [2:0] KindRefill = 3'd1;
  localparam logic [2:0] KindWrite  = 3'd2;
  localparam logic [2:0] KindFlush  = 3'd3;
  localparam logic [2:0] KindError  = 3'd4;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] addr;
    logic [2:0]  length;
    logic [31:0] write_data;
    logic [31:0] fill_word;
  } req_t;

  typedef struct packed {
    logic [2:0]  resp_kind;
    logic [31:0] resp_addr;
    logic [31:0] resp_data;
    logic [2:0]  resp_len;
    logic        was_hit;
  } resp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       latch;
    logic       tag_rd;
    logic       cmp;
    logic       fill_wr;
    logic       flush;
    logic       miss_start;
    logic       wr0;
    logic       wr1;
    logic       data_rd;
    logic       sel_refill;
    logic       emit;
    logic [2:0] kind;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic       rbusy;
    logic [1:0] req_type;
    logic       bad;
    logic       fill_last;
    logic       hit;
    logic       span;
    logic       clearing;
  } sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/sawtc_dpath.sv =====
// Datapath of the cache unit: request latch, valid bits, tag and data memories,
// refill state and the result register. Depends on sawtc_pkg.
`default_nettype none

module sawtc_dpath #(
  parameter int OFFSET_BITS = sawtc_pkg::OffsetBitsDef,
  parameter int WAY_BITS    = sawtc_pkg::WayBitsDef,
  parameter int SET_BITS    = sawtc_pkg::SetBitsDef
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  sawtc_pkg::req_t     req_i,
  input  sawtc_pkg::cmd_t     cmd_i,
  output sawtc_pkg::sts_t     sts_o,
  output logic                resp_valid_o,
  output sawtc_pkg::resp_t    resp_o
);

  localparam int NWAYS      = 1 << WAY_BITS;
  localparam int NSETS      = 1 << SET_BITS;
  localparam int LINE_BYTES = 1 << OFFSET_BITS;
  localparam int LINE_WORDS = 1 << (OFFSET_BITS - 2);
  localparam int TAG_SHIFT  = OFFSET_BITS + SET_BITS;
  localparam int TAG_BITS   = 32 - TAG_SHIFT;
  localparam int WAY_W      = (WAY_BITS > 0) ? WAY_BITS : 1;
  localparam int WIDX_W     = (OFFSET_BITS > 2) ? OFFSET_BITS - 2 : 1;
  localparam int DADDR_W    = SET_BITS + WAY_BITS + OFFSET_BITS - 2;
  localparam int DEPTH      = 1 << DADDR_W;

  // Word address of a line word inside the data memory.
  function automatic logic [DADDR_W-1:0] word_addr(input logic [SET_BITS-1:0] set,
                                                   input logic [WAY_W-1:0] way,
                                                   input logic [WIDX_W-1:0] widx);
    logic [DADDR_W-1:0] a;
    a = (DADDR_W'(set) << (WAY_BITS + OFFSET_BITS - 2))
      | (DADDR_W'(way & WAY_W'(NWAYS - 1)) << (OFFSET_BITS - 2))
      | DADDR_W'(widx & WIDX_W'(LINE_WORDS - 1));
    return a;
  endfunction

  // Byte mask of the low len bytes of a word.
  function automatic logic [3:0] len_mask(input logic [2:0] len);
    logic [4:0] m;
    m = (5'd1 << len) - 5'd1;
    return m[3:0];
  endfunction

  function automatic logic [31:0] expand(input logic [3:0] m);
    logic [31:0] r;
    for (int b = 0; b < 4; b++) begin
      r[8*b +: 8] = {8{m[b]}};
    end
    return r;
  endfunction

  sawtc_pkg::req_t req_q;

  logic                 hit_q;
  logic [WAY_W-1:0]     hit_way_q, victim_q;
  logic                 rbusy_q;
  logic [31:0]          raddr_q;
  logic [2:0]           rlen_q;
  logic [WAY_W-1:0]     rway_q;
  logic [WIDX_W-1:0]    rcount_q;
  logic [NWAYS-1:0]     vmem [NSETS];
  logic [NWAYS-1:0]     vrow_q;
  logic                 clr_q;
  logic [SET_BITS-1:0]  clr_idx_q;

  logic [NWAYS-1:0][TAG_BITS-1:0] tmem [NSETS];
  logic [NWAYS-1:0][TAG_BITS-1:0] tag_rd_q;
  logic [3:0][7:0]                dmem [DEPTH];
  logic [31:0]                    rd0_q, rd1_q;

  logic                 resp_valid_q;
  sawtc_pkg::resp_t     resp_q;

  // Field decoding of the latched request and of the pending refill.
  logic [SET_BITS-1:0]    req_set, r_set, cur_set;
  logic [TAG_BITS-1:0]    req_tag, r_tag;
  logic [OFFSET_BITS-1:0] req_off, cur_off;
  logic [2:0]             cur_len;
  logic [WAY_W-1:0]       cur_way;
  logic [1:0]             bsh;
  logic [WIDX_W-1:0]      widx0, widx1;

  assign req_set = req_q.addr[TAG_SHIFT-1:OFFSET_BITS];
  assign req_tag = req_q.addr[31:TAG_SHIFT];
  assign req_off = req_q.addr[OFFSET_BITS-1:0];
  assign r_set   = raddr_q[TAG_SHIFT-1:OFFSET_BITS];
  assign r_tag   = raddr_q[31:TAG_SHIFT];
  assign cur_set = cmd_i.sel_refill ? r_set : req_set;
  assign cur_off = cmd_i.sel_refill ? raddr_q[OFFSET_BITS-1:0] : req_off;
  assign cur_len = cmd_i.sel_refill ? rlen_q : req_q.length;
  assign cur_way = cmd_i.sel_refill ? rway_q : hit_way_q;
  assign bsh     = cur_off[1:0];
  assign widx0   = WIDX_W'(cur_off >> 2);
  assign widx1   = widx0 + WIDX_W'(1);

  // Error checks on length and line crossing, and the two-word span.
  logic [OFFSET_BITS+1:0] end_off;
  logic [3:0]             word_end;
  logic                   bad, span, fill_last;

  assign end_off   = (OFFSET_BITS+2)'(req_off) + (OFFSET_BITS+2)'(req_q.length);
  assign bad       = (req_q.length == 3'd0) || (req_q.length > 3'd4) ||
                     (end_off > (OFFSET_BITS+2)'(LINE_BYTES));
  assign word_end  = {2'b00, req_off[1:0]} + {1'b0, req_q.length};
  assign span      = word_end > 4'd4;
  assign fill_last = rcount_q == WIDX_W'(LINE_WORDS - 1);

  always_comb begin
    sts_o.rbusy     = rbusy_q;
    sts_o.req_type  = req_q.req_type;
    sts_o.bad       = bad;
    sts_o.fill_last = fill_last;
    sts_o.hit       = hit_q;
    sts_o.span      = span;
    sts_o.clearing  = clr_q;
  end

  // Request latch.
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      req_q <= req_i;
    end
  end

  // Tag compare, lowest hitting way and victim choice.
  logic             any_hit, any_inv;
  logic [WAY_W-1:0] hway, iway, vway;

  always_comb begin
    any_hit = 1'b0;
    any_inv = 1'b0;
    hway    = '0;
    iway    = '0;
    for (int w = NWAYS - 1; w >= 0; w--) begin
      if (vrow_q[w] && (tag_rd_q[w] == req_tag)) begin
        any_hit = 1'b1;
        hway    = WAY_W'(w);
      end
      if (!vrow_q[w]) begin
        any_inv = 1'b1;
        iway    = WAY_W'(w);
      end
    end
    vway = any_inv ? iway
                   : ((WAY_W'(req_tag) + WAY_W'(req_set)) & WAY_W'(NWAYS - 1));
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cmp) begin
      hit_q     <= any_hit;
      hit_way_q <= hway;
      victim_q  <= vway;
    end
  end

  // Refill state and the valid clearing pass that follows reset and each flush.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rbusy_q   <= 1'b0;
      raddr_q   <= '0;
      rlen_q    <= '0;
      rway_q    <= '0;
      rcount_q  <= '0;
      clr_q     <= 1'b1;
      clr_idx_q <= '0;
    end else begin
      if (cmd_i.flush) begin
        clr_q     <= 1'b1;
        clr_idx_q <= '0;
      end else if (clr_q) begin
        clr_idx_q <= clr_idx_q + SET_BITS'(1);
        if (clr_idx_q == SET_BITS'(NSETS - 1)) begin
          clr_q <= 1'b0;
        end
      end
      if (cmd_i.miss_start) begin
        rbusy_q  <= 1'b1;
        raddr_q  <= req_q.addr;
        rlen_q   <= req_q.length;
        rway_q   <= victim_q;
        rcount_q <= '0;
      end
      if (cmd_i.fill_wr) begin
        if (fill_last) begin
          rbusy_q  <= 1'b0;
          rcount_q <= '0;
        end else begin
          rcount_q <= rcount_q + WIDX_W'(1);
        end
      end
    end
  end

  // Valid memory: cleared one set per cycle, one bit written per update, read once
  // per access together with the tags.
  always_ff @(posedge clk_i) begin
    if (clr_q) begin
      vmem[clr_idx_q] <= '0;
    end else if (cmd_i.miss_start) begin
      vmem[req_set][victim_q] <= 1'b0;
    end else if (cmd_i.fill_wr && fill_last) begin
      vmem[r_set][rway_q] <= 1'b1;
    end
    if (cmd_i.tag_rd) begin
      vrow_q <= vmem[req_set];
    end
  end

  // Tag memory: written when a refill completes, read once per access.
  always_ff @(posedge clk_i) begin
    if (cmd_i.fill_wr && fill_last) begin
      tmem[r_set][rway_q] <= r_tag;
    end
    if (cmd_i.tag_rd) begin
      tag_rd_q <= tmem[req_set];
    end
  end

  // Data memory write port: fill words or the two halves of a store.
  logic [7:0]         be8;
  logic [63:0]        wd64;
  logic               dwe;
  logic [DADDR_W-1:0] dwaddr;
  logic [3:0]         dwbe;
  logic [31:0]        dwdata;

  assign be8  = 8'({4'b0000, len_mask(req_q.length)} << req_off[1:0]);
  assign wd64 = {32'd0, req_q.write_data} << {req_off[1:0], 3'b000};

  always_comb begin
    dwe    = 1'b0;
    dwaddr = word_addr(r_set, rway_q, rcount_q);
    dwbe   = 4'hF;
    dwdata = req_q.fill_word;
    if (cmd_i.fill_wr) begin
      dwe = 1'b1;
    end else if (cmd_i.wr0) begin
      dwe    = 1'b1;
      dwaddr = word_addr(req_set, hit_way_q, widx0);
      dwbe   = be8[3:0];
      dwdata = wd64[31:0];
    end else if (cmd_i.wr1) begin
      dwe    = 1'b1;
      dwaddr = word_addr(req_set, hit_way_q, widx1);
      dwbe   = be8[7:4];
      dwdata = wd64[63:32];
    end
  end

  always_ff @(posedge clk_i) begin
    if (dwe) begin
      for (int b = 0; b < 4; b++) begin
        if (dwbe[b]) begin
          dmem[dwaddr][b] <= dwdata[8*b +: 8];
        end
      end
    end
    if (cmd_i.data_rd) begin
      rd0_q <= dmem[word_addr(cur_set, cur_way, widx0)];
      rd1_q <= dmem[word_addr(cur_set, cur_way, widx1)];
    end
  end

  // Read data alignment.
  logic [63:0] rd64;
  logic [31:0] rdata;

  assign rd64  = {rd1_q, rd0_q} >> {bsh, 3'b000};
  assign rdata = rd64[31:0] & expand(len_mask(cur_len));

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      resp_valid_q <= 1'b0;
    end else begin
      resp_valid_q <= cmd_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      resp_q.resp_kind <= cmd_i.kind;
      resp_q.resp_addr <= '0;
      resp_q.resp_data <= '0;
      resp_q.resp_len  <= '0;
      resp_q.was_hit   <= 1'b0;
      case (cmd_i.kind)
        sawtc_pkg::KindRead: begin
          resp_q.resp_data <= rdata;
          resp_q.resp_len  <= cur_len;
          resp_q.was_hit   <= hit_q & ~cmd_i.sel_refill;
        end
        sawtc_pkg::KindRefill: begin
          resp_q.resp_addr <= req_q.addr & ~32'(LINE_BYTES - 1);
        end
        sawtc_pkg::KindWrite: begin
          resp_q.resp_addr <= req_q.addr;
          resp_q.resp_data <= req_q.write_data & expand(len_mask(req_q.length));
          resp_q.resp_len  <= req_q.length;
          resp_q.was_hit   <= hit_q;
        end
        default: begin
        end
      endcase
    end
  end

  assign resp_valid_o = resp_valid_q;
  assign resp_o       = resp_q;

endmodule

`default_nettype wire

// ===== rtl/core/sawtc_ctrl.sv =====
// Controller state machine of the cache unit: sequences one request at a time.
// Depends on sawtc_pkg.
`default_nettype none

module sawtc_ctrl (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              start_i,
  input  sawtc_pkg::sts_t  sts_i,
  output logic             busy_o,
  output sawtc_pkg::cmd_t  cmd_o
);

  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StDecode = 3'd1;
  localparam logic [2:0] StTag    = 3'd2;
  localparam logic [2:0] StAct    = 3'd3;
  localparam logic [2:0] StWr1    = 3'd4;
  localparam logic [2:0] StRd     = 3'd5;
  localparam logic [2:0] StRdOut  = 3'd6;

  logic [2:0] state_q, state_d;
  logic       rd_refill_q, rd_refill_d;

  // Next state and command decode.
  always_comb begin
    state_d     = state_q;
    rd_refill_d = rd_refill_q;
    cmd_o       = '0;
    cmd_o.kind  = sawtc_pkg::KindError;
    case (state_q)
      StIdle: begin
        if (start_i && !sts_i.clearing) begin
          cmd_o.latch = 1'b1;
          state_d     = StDecode;
        end
      end
      StDecode: begin
        state_d = StIdle;
        if (sts_i.req_type == sawtc_pkg::ReqFill) begin
          if (sts_i.rbusy) begin
            cmd_o.fill_wr = 1'b1;
            if (sts_i.fill_last) begin
              rd_refill_d = 1'b1;
              state_d     = StRd;
            end
          end
        end else if (sts_i.rbusy) begin
          cmd_o.emit = 1'b1;
          cmd_o.kind = sawtc_pkg::KindError;
        end else if (sts_i.req_type == sawtc_pkg::ReqFlush) begin
          cmd_o.flush = 1'b1;
          cmd_o.emit  = 1'b1;
          cmd_o.kind  = sawtc_pkg::KindFlush;
        end else if (sts_i.bad) begin
          cmd_o.emit = 1'b1;
          cmd_o.kind = sawtc_pkg::KindError;
        end else begin
          cmd_o.tag_rd = 1'b1;
          state_d      = StTag;
        end
      end
      StTag: begin
        cmd_o.cmp = 1'b1;
        state_d   = StAct;
      end
      StAct: begin
        state_d = StIdle;
        if (sts_i.req_type == sawtc_pkg::ReqWrite) begin
          cmd_o.wr0  = sts_i.hit;
          cmd_o.emit = 1'b1;
          cmd_o.kind = sawtc_pkg::KindWrite;
          if (sts_i.hit && sts_i.span) begin
            state_d = StWr1;
          end
        end else if (sts_i.hit) begin
          rd_refill_d = 1'b0;
          state_d     = StRd;
        end else begin
          cmd_o.miss_start = 1'b1;
          cmd_o.emit       = 1'b1;
          cmd_o.kind       = sawtc_pkg::KindRefill;
        end
      end
      StWr1: begin
        cmd_o.wr1 = 1'b1;
        state_d   = StIdle;
      end
      StRd: begin
        cmd_o.data_rd    = 1'b1;
        cmd_o.sel_refill = rd_refill_q;
        state_d          = StRdOut;
      end
      StRdOut: begin
        cmd_o.emit       = 1'b1;
        cmd_o.kind       = sawtc_pkg::KindRead;
        cmd_o.sel_refill = rd_refill_q;
        state_d          = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      rd_refill_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rd_refill_q <= rd_refill_d;
    end
  end

  // The block is also held busy while the valid bits are being cleared.
  assign busy_o = (state_q != StIdle) || sts_i.clearing;

endmodule

`default_nettype wire

// ===== rtl/core/set_assoc_write_through_cache_unit.sv =====
// A fill word is written in the decode state, which also emits flush and error results;
// writes and refill requests are emitted in the act state, reads in the read-out state.
// One request is in flight; the sequence runs tag and valid read, compare, then data read.
// A stored write crossing two words takes a second write state. The receiver cannot stall.
// Reset and each flush clear the valid bits one set per cycle and the block stays busy until
// all are clear; refill state resets at once and the tag and data memories are not cleared.
`default_nettype none

`include "set_assoc_write_through_cache_unit_macros.svh"

module set_assoc_write_through_cache_unit #(
  parameter int OFFSET_BITS = sawtc_pkg::OffsetBitsDef,
  parameter int WAY_BITS    = sawtc_pkg::WayBitsDef,
  parameter int SET_BITS    = sawtc_pkg::SetBitsDef
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               start_i,
  output logic              busy_o,
  input  sawtc_pkg::req_t   req_i,
  output logic              resp_valid_o,
  output sawtc_pkg::resp_t  resp_o
);

  sawtc_pkg::cmd_t cmd;
  sawtc_pkg::sts_t sts;

  // Controller.
  sawtc_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .sts_i  (sts),
    .busy_o (busy_o),
    .cmd_o  (cmd)
  );

  // Datapath.
  sawtc_dpath #(
    .OFFSET_BITS(OFFSET_BITS),
    .WAY_BITS   (WAY_BITS),
    .SET_BITS   (SET_BITS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .resp_valid_o(resp_valid_o),
    .resp_o      (resp_o)
  );

  // A result only follows a cycle in which a request was being worked on.
  `SAWTC_ASSERT_NOW(a_resp_after_busy, clk_i, rst_ni, resp_valid_o, $past(busy_o))
  // An accepted request always occupies the block in the next cycle.
  `SAWTC_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, start_i && !busy_o, busy_o)
  // Read data always carries a byte count of one to four.
  `SAWTC_ASSERT_NOW(a_read_len, clk_i, rst_ni,
                    resp_valid_o && (resp_o.resp_kind == sawtc_pkg::KindRead),
                    (resp_o.resp_len != 3'd0) && (resp_o.resp_len <= 3'd4))

endmodule

`default_nettype wire
